// ----- sv/pln_pkg.sv -----
// Shared types, codes and helpers for the palette lookup and nearest-color block.
// No dependencies. Used by palette_lookup_and_nearest.
package pln_pkg;

	localparam int unsigned ColorW = 6;
	localparam int unsigned WideW  = 8;
	localparam int unsigned IndexW = 8;
	localparam int unsigned EntryW = 3 * ColorW;
	localparam int unsigned DistW  = 18;   // 3 * 255^2 = 195075 fits in 18 bits

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_LOOKUP  = 2'd1,
		OP_NEAREST = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		op_t               operation;
		logic [IndexW-1:0] index;
		logic [ColorW-1:0] new_red6;
		logic [ColorW-1:0] new_green6;
		logic [ColorW-1:0] new_blue6;
		logic [WideW-1:0]  query_red;
		logic [WideW-1:0]  query_green;
		logic [WideW-1:0]  query_blue;
	} item_t;

	typedef struct packed {
		logic [WideW-1:0]  out_red;
		logic [WideW-1:0]  out_green;
		logic [WideW-1:0]  out_blue;
		logic [IndexW-1:0] nearest_index;
	} result_t;

	// 6-bit channel to 8-bit by replicating the top bits, so 63 maps to 255
	function automatic logic [WideW-1:0] widen(input logic [ColorW-1:0] c);
		widen = {c, c[ColorW-1 -: 2]};
	endfunction

	// squared distance of one channel
	function automatic logic [2*WideW-1:0] sq_diff(input logic [WideW-1:0] a,
		input logic [WideW-1:0] b);
		logic [WideW-1:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		sq_diff = d * d;
	endfunction

endpackage

// ----- sv/palette_lookup_and_nearest.sv -----
// Top level of the palette lookup and nearest-color search.
// Depends on pln_pkg and pln_ram.
//
// Usage:
//   An item is taken on a rising edge with start high and busy low. Its
//   operation selects write entry, look up entry, or find nearest entry.
//   Every item gives exactly one result on the result port, marked by done
//   for one cycle; the receiver cannot stall it.
// Per operation:
//   write / unused code : result in the cycle after the item, busy stays low,
//                         so a new item can follow in the next cycle.
//   lookup              : one palette read in the look state, then the result register.
//   nearest             : one palette entry read per cycle from the single
//                         read port, then a distance stage and a compare
//                         stage before the result.
// Entries at or beyond ENTRIES are never written and read as black.
// Reset: the palette reads as all zero at once through per-entry valid
// bits that reset clears; no clearing pass is needed. Nothing is in flight
// after reset and done is low.
module palette_lookup_and_nearest
	import pln_pkg::*;
#(
	parameter int unsigned ENTRIES = 256
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	state_t state_q, state_d;

	logic              accept;
	logic              in_range;
	logic              we;
	logic [AW-1:0]     raddr;
	logic [EntryW-1:0] rdata;

	logic [ENTRIES-1:0] valid_q;
	logic [AW-1:0]      cnt_q;
	logic               scan_last;
	logic [AW-1:0]      idx_q;
	logic               in_range_q;
	logic [WideW-1:0]   qry_r_q, qry_g_q, qry_b_q;

	// scan pipeline: s1 = palette data back, s2 = distance ready
	logic              v_s1, v_s2;
	logic              ok_s1;
	logic              first_s1, first_s2;
	logic              last_s1, last_s2;
	logic [AW-1:0]     idx_s1, idx_s2;
	logic [DistW-1:0]  d_s2;
	logic [DistW-1:0]  best_d_q;
	logic [AW-1:0]     best_idx_q;
	logic              take;
	logic              finish;

	logic [WideW-1:0]  cand_r, cand_g, cand_b;
	logic [DistW-1:0]  cand_dist;

	result_t result_q;
	logic    done_q;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign in_range  = ({1'b0, item.index} < 9'(ENTRIES));
	assign we        = accept && (item.operation == OP_WRITE) && in_range;
	assign scan_last = (cnt_q == AW'(ENTRIES - 1));
	assign raddr     = (state_q == ST_SCAN) ? cnt_q : item.index[AW-1:0];
	assign finish    = v_s2 && last_s2;
	assign take      = first_s2 || (d_s2 < best_d_q);

	// Palette memory. Writes happen only while idle, so a scan or a lookup
	// never overlaps a write; a lookup right after a write sees the new data.
	pln_ram #(
		.WIDTH(EntryW),
		.DEPTH(ENTRIES),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(item.index[AW-1:0]),
		.wdata({item.new_red6, item.new_green6, item.new_blue6}),
		.raddr(raddr),
		.rdata(rdata)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (item.operation)
						OP_LOOKUP:  state_d = ST_LOOK;
						OP_NEAREST: state_d = ST_SCAN;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOOK:  state_d = ST_IDLE;
			ST_SCAN:  if (scan_last) state_d = ST_DRAIN;
			ST_DRAIN: if (finish) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Candidate color and its squared distance to the query
	always_comb begin
		cand_r    = ok_s1 ? widen(rdata[3*ColorW-1 -: ColorW]) : '0;
		cand_g    = ok_s1 ? widen(rdata[2*ColorW-1 -: ColorW]) : '0;
		cand_b    = ok_s1 ? widen(rdata[ColorW-1:0]) : '0;
		cand_dist = DistW'(sq_diff(cand_r, qry_r_q)) + DistW'(sq_diff(cand_g, qry_g_q))
			+ DistW'(sq_diff(cand_b, qry_b_q));
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (we) begin
				valid_q[item.index[AW-1:0]] <= 1'b1;
			end
			v_s1   <= (state_q == ST_SCAN);
			v_s2   <= v_s1;
			done_q <= (accept && (item.operation != OP_LOOKUP)
				&& (item.operation != OP_NEAREST))
				|| (state_q == ST_LOOK) || finish;
			if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q      <= item.index[AW-1:0];
			in_range_q <= in_range;
			qry_r_q    <= item.query_red;
			qry_g_q    <= item.query_green;
			qry_b_q    <= item.query_blue;
		end
		// stage 1: address issued this cycle, data arrives with it
		ok_s1    <= valid_q[cnt_q];
		idx_s1   <= cnt_q;
		first_s1 <= (cnt_q == '0);
		last_s1  <= scan_last;
		// stage 2: distance
		d_s2     <= cand_dist;
		idx_s2   <= idx_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		// running best, lowest index wins ties
		if (v_s2 && take) begin
			best_d_q   <= d_s2;
			best_idx_q <= idx_s2;
		end
		// result
		if (state_q == ST_LOOK && in_range_q && valid_q[idx_q]) begin
			result_q <= {widen(rdata[3*ColorW-1 -: ColorW]),
				widen(rdata[2*ColorW-1 -: ColorW]), widen(rdata[ColorW-1:0]),
				{IndexW{1'b0}}};
		end else if (finish) begin
			result_q <= {{3*WideW{1'b0}}, IndexW'(take ? idx_s2 : best_idx_q)};
		end else begin
			result_q <= '0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// Checks
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !we)
		else $error("palette written while busy");

	a_look_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |=> done)
		else $error("lookup gave no result");

	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (done && state_q == ST_IDLE))
		else $error("nearest search did not end with a result");

	a_scan_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !done)
		else $error("result strobe during a scan");

	a_pipe_only_scan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("scan pipeline active outside a search");

endmodule

// ----- sv/pln_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pln_ram #(
	parameter int unsigned WIDTH = 18,
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for palette_lookup_and_nearest: writes, lookups and nearest-color searches.
// It models the palette itself and checks every result in order.
// Depends on pln_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
	import pln_pkg::*;

	localparam int unsigned ENTRIES      = 256;
	localparam int unsigned RANDOM_ITEMS = 1900;
	localparam int unsigned MAX_REPORTS  = 200;
	localparam op_t         OP_UNUSED    = op_t'(2'd3);

	// Palette model plus the in-order list of answers the block still owes
	class palette_checker;
		logic [EntryW-1:0] palette [256];
		result_t           owed_results [$];
		int unsigned       errors;

		function new();
			foreach (palette[i]) palette[i] = '0;
			errors = 0;
		endfunction

		// 6-bit channel to 8 bits: shift up and refill the low bits from the top
		function logic [7:0] widen6(logic [5:0] c);
			logic [7:0] w;
			w = {2'b00, c};
			return (w << 2) | (w >> 4);
		endfunction

		function int sq_gap(logic [7:0] a, logic [7:0] b);
			int d;
			d = int'(a) - int'(b);
			return d * d;
		endfunction

		// Applies one item to the model and returns the answer it should give
		function result_t palette_answer(item_t it);
			result_t ans;
			int      best;
			int      cost;
			ans  = '0;
			best = -1;
			case (it.operation)
				OP_WRITE: begin
					if (it.index < ENTRIES)
						palette[it.index] = {it.new_red6, it.new_green6, it.new_blue6};
				end
				OP_LOOKUP: begin
					if (it.index < ENTRIES) begin
						ans.out_red   = widen6(palette[it.index][17:12]);
						ans.out_green = widen6(palette[it.index][11:6]);
						ans.out_blue  = widen6(palette[it.index][5:0]);
					end
				end
				OP_NEAREST: begin
					// strict less-than keeps the lowest index on ties
					for (int i = 0; i < ENTRIES; i++) begin
						cost = sq_gap(widen6(palette[i][17:12]), it.query_red)
							+ sq_gap(widen6(palette[i][11:6]), it.query_green)
							+ sq_gap(widen6(palette[i][5:0]), it.query_blue);
						if (best < 0 || cost < best) begin
							best = cost;
							ans.nearest_index = i[7:0];
						end
					end
				end
				default: ;
			endcase
			return ans;
		endfunction

		function void note_item(item_t it);
			owed_results = {owed_results, palette_answer(it)};
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (owed_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result expected none, got %h", $time, got);
				return;
			end
			want = owed_results.pop_front();
			compare_field("out_red", want.out_red, got.out_red);
			compare_field("out_green", want.out_green, got.out_green);
			compare_field("out_blue", want.out_blue, got.out_blue);
			compare_field("nearest_index", want.nearest_index, got.nearest_index);
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    done;
	result_t result;

	palette_checker sb = new();

	palette_lookup_and_nearest #(
		.ENTRIES(ENTRIES)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.done  (done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Results last one cycle; sample mid-cycle
	always @(negedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	// Called at a rising edge; returns at the edge that took the item
	task automatic send_item(input item_t it);
		bit taken;
		start <= 1'b1;
		item  <= it;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		sb.note_item(it);
	endtask

	task automatic pause(input int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Hold off until every owed result is in
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.owed_results.size() != 0);
	endtask

	function automatic item_t make_item(op_t op, logic [7:0] idx, logic [5:0] r6,
		logic [5:0] g6, logic [5:0] b6, logic [7:0] qr, logic [7:0] qg, logic [7:0] qb);
		item_t it;
		it.operation   = op;
		it.index       = idx;
		it.new_red6    = r6;
		it.new_green6  = g6;
		it.new_blue6   = b6;
		it.query_red   = qr;
		it.query_green = qg;
		it.query_blue  = qb;
		return it;
	endfunction

	// Query channel close to a palette channel, clamped to 0..255
	function automatic logic [7:0] near_channel(logic [5:0] c6);
		int v;
		v = int'(sb.widen6(c6)) + int'($urandom_range(6)) - 3;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return v[7:0];
	endfunction

	function automatic item_t random_item();
		item_t             it;
		logic [63:0]       raw;
		logic [EntryW-1:0] entry;
		int unsigned       pick;
		raw  = {$urandom(), $urandom()};
		it   = raw[$bits(item_t)-1:0];
		pick = $urandom_range(99);
		if (pick < 40)
			it.operation = OP_WRITE;
		else if (pick < 68)
			it.operation = OP_LOOKUP;
		else if (pick < 95)
			it.operation = OP_NEAREST;
		else
			it.operation = OP_UNUSED;
		// half the searches aim close to a color already in the palette
		if (it.operation == OP_NEAREST && $urandom_range(1) == 1) begin
			entry          = sb.palette[$urandom_range(ENTRIES - 1)];
			it.query_red   = near_channel(entry[17:12]);
			it.query_green = near_channel(entry[11:6]);
			it.query_blue  = near_channel(entry[5:0]);
		end
		return it;
	endfunction

	task automatic run_phase(input int unsigned count, input int unsigned idle_pct);
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(99) < idle_pct)
				pause($urandom_range(1, 6));
			send_item(random_item());
		end
	endtask

	task automatic directed_items();
		// empty palette: all entries tie, lowest wins
		send_item(make_item(OP_NEAREST, 8'd0, 6'd0, 6'd0, 6'd0, 8'd255, 8'd255, 8'd255));
		send_item(make_item(OP_LOOKUP, 8'd255, 6'd63, 6'd63, 6'd63, 8'd255, 8'd255, 8'd255));
		// extremes of index and color; unused query fields hold all ones, all zeros or mixed bits
		send_item(make_item(OP_WRITE, 8'd0, 6'd63, 6'd63, 6'd63, 8'd255, 8'd255, 8'd255));
		send_item(make_item(OP_WRITE, 8'd255, 6'd63, 6'd0, 6'd63, 8'd0, 8'd0, 8'd0));
		send_item(make_item(OP_WRITE, 8'd128, 6'd0, 6'd63, 6'd0, 8'd170, 8'd85, 8'd170));
		send_item(make_item(OP_LOOKUP, 8'd0, 6'd0, 6'd0, 6'd0, 8'd0, 8'd0, 8'd0));
		send_item(make_item(OP_LOOKUP, 8'd255, 6'd0, 6'd0, 6'd0, 8'd0, 8'd0, 8'd0));
		send_item(make_item(OP_LOOKUP, 8'd128, 6'd63, 6'd63, 6'd63, 8'd255, 8'd255, 8'd255));
		send_item(make_item(OP_LOOKUP, 8'd1, 6'd0, 6'd0, 6'd0, 8'd0, 8'd0, 8'd0));
		// unused operation code changes nothing
		send_item(make_item(OP_UNUSED, 8'd255, 6'd63, 6'd63, 6'd63, 8'd255, 8'd255, 8'd255));
		send_item(make_item(OP_NEAREST, 8'd255, 6'd63, 6'd63, 6'd63, 8'd255, 8'd255, 8'd255));
		send_item(make_item(OP_NEAREST, 8'd0, 6'd0, 6'd0, 6'd0, 8'd255, 8'd0, 8'd255));
		send_item(make_item(OP_NEAREST, 8'd0, 6'd0, 6'd0, 6'd0, 8'd0, 8'd0, 8'd0));
		send_item(make_item(OP_NEAREST, 8'd0, 6'd0, 6'd0, 6'd0, 8'd0, 8'd255, 8'd0));
		// two identical entries: the lower index must win
		send_item(make_item(OP_WRITE, 8'd20, 6'd20, 6'd30, 6'd40, 8'd0, 8'd0, 8'd0));
		send_item(make_item(OP_WRITE, 8'd10, 6'd20, 6'd30, 6'd40, 8'd0, 8'd0, 8'd0));
		send_item(make_item(OP_NEAREST, 8'd0, 6'd0, 6'd0, 6'd0, 8'd81, 8'd121, 8'd162));
		send_item(make_item(OP_LOOKUP, 8'd10, 6'd0, 6'd0, 6'd0, 8'd0, 8'd0, 8'd0));
		send_item(make_item(OP_WRITE, 8'd0, 6'd0, 6'd0, 6'd0, 8'd0, 8'd0, 8'd0));
		send_item(make_item(OP_NEAREST, 8'd0, 6'd0, 6'd0, 6'd0, 8'd0, 8'd0, 8'd0));
	endtask

	// Main sequence
	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_items();
		drain();

		run_phase(RANDOM_ITEMS / 6, 33);
		drain();
		run_phase(RANDOM_ITEMS / 6, 33);
		drain();
		run_phase(RANDOM_ITEMS / 3, 68);
		drain();
		run_phase(RANDOM_ITEMS / 3, 0);
		drain();

		repeat (ENTRIES + 8) @(posedge clk);
		if (sb.owed_results.size() != 0) begin
			sb.errors++;
			$display("%0t: %0d results expected, none got", $time, sb.owed_results.size());
		end
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Timeout
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ----- files.f -----
sv/pln_pkg.sv
sv/pln_ram.sv
sv/palette_lookup_and_nearest.sv
tb/tb_top.sv
